FILE: hdl/srsw_pkg.sv
// shared types, widths and codes of the selective-repeat send window
`default_nettype none

package srsw_pkg;

  localparam int unsigned WindowSlotsDef = 16;
  localparam int unsigned PacketBytesDef = 1024;
  localparam int unsigned ResultCap      = 16;

  localparam int unsigned LenW    = 31;
  localparam int unsigned LimW    = 5;
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdxW    = 22;
  localparam int unsigned KindW   = 3;
  localparam int unsigned BlkLenW = 11;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [LenW-1:0] TransferLengthRst = LenW'(1);
  localparam logic [LimW-1:0] WindowLimitRst    = LimW'(10);

  localparam logic [0:0] REG_TRANSFER_LENGTH = 1'b0;
  localparam logic [0:0] REG_WINDOW_LIMIT    = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [KindW-1:0] {
    EV_SEND    = 3'd0,
    EV_RESEND  = 3'd1,
    EV_IGNORED = 3'd2,
    EV_DONE    = 3'd3,
    EV_NONE    = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SLIDE,
    ST_FILL,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    event_e              kind;
    logic [IdxW-1:0]     idx;
    logic [BlkLenW-1:0]  len;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/srsw_if.sv
// valid/ready channels for input items and result items
`default_nettype none

interface srsw_req_if import srsw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  operation;
  logic [IdxW-1:0] ack_index;

  modport source (output valid, operation, ack_index, input ready);
  modport sink   (input valid, operation, ack_index, output ready);
endinterface

interface srsw_rsp_if import srsw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   event_kind;
  logic [IdxW-1:0]    block_index;
  logic [BlkLenW-1:0] block_length;
  logic               last;

  modport source (output valid, event_kind, block_index, block_length, last, input ready);
  modport sink   (input valid, event_kind, block_index, block_length, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/srsw_div.sv
// reciprocal-multiply divider that splits the transfer length into full blocks and a remainder
`default_nettype none

module srsw_div import srsw_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PacketBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [LenW-1:0]    dividend_i,
  output logic                    done_o,
  output logic [IdxW-1:0]         quotient_o,
  output logic [BlkLenW-1:0]      remainder_o
);

  localparam int unsigned     RemW      = $clog2(PACKET_BYTES) + 1;
  localparam int unsigned     RecW      = LenW + 2 - $clog2(PACKET_BYTES);
  localparam int unsigned     ProdW     = LenW + RecW;
  localparam int unsigned     BackW     = RecW + RemW;
  localparam longint unsigned RecipFull = (64'd1 << LenW) / PACKET_BYTES;
  localparam logic [RecW-1:0] Recip     = RecW'(RecipFull);
  localparam logic [RemW-1:0] Divisor   = RemW'(PACKET_BYTES);

  logic [2:0]       stage_q;
  logic             done_q;
  logic [LenW-1:0]  num_q;
  logic [RecW-1:0]  q0_q;
  logic [RemW:0]    r0_q;
  logic [IdxW-1:0]  quot_q;
  logic [RemW-1:0]  rem_q;
  logic [ProdW-1:0] prod;
  logic [BackW-1:0] back;
  logic [LenW-1:0]  diff;
  logic             fits;

  // estimate is low by at most one, one compare and subtract corrects it
  assign prod = ProdW'(num_q) * ProdW'(Recip);
  assign back = BackW'(q0_q) * BackW'(Divisor);
  assign diff = num_q - back[LenW-1:0];
  assign fits = (r0_q >= {1'b0, Divisor});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
      done_q  <= stage_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) num_q <= dividend_i;
    if (stage_q[0]) q0_q <= prod[LenW +: RecW];
    if (stage_q[1]) r0_q <= diff[RemW:0];
    if (stage_q[2]) begin
      quot_q <= IdxW'(q0_q) + IdxW'(fits);
      rem_q  <= fits ? RemW'(r0_q - {1'b0, Divisor}) : RemW'(r0_q);
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = BlkLenW'(rem_q);

endmodule

`default_nettype wire

FILE: hdl/selective_repeat_send_window.sv
// selective-repeat sliding-window sender: top level with sequencer and register port
// One input item is taken at a time; ready stays low until its last result has been handed
// to the output register. A start keeps ready low while the length divider runs, then while
// each new block is issued, then through the closing state. An acknowledgement inside the
// window slides the lower bound over acknowledged slots, then issues new blocks; one outside
// the window goes straight to the closing state. A timeout walks the window slot by slot and
// resends each unacknowledged block. Results leave one per cycle while the consumer keeps
// ready high; a back-pressured output stalls the walk.
// There is no clearing pass after reset.
`default_nettype none

module selective_repeat_send_window import srsw_pkg::*; #(
  parameter int unsigned WINDOW_SLOTS = WindowSlotsDef,
  parameter int unsigned PACKET_BYTES = PacketBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  srsw_req_if.sink                req_i,
  srsw_rsp_if.source              rsp_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  localparam int unsigned SlotW  = $clog2(WINDOW_SLOTS);
  localparam int unsigned WinW   = IdxW + 1;
  localparam int unsigned LimMax = (WINDOW_SLOTS < ResultCap) ? WINDOW_SLOTS : ResultCap;
  localparam logic [SlotW-1:0]  SlotLast = SlotW'(WINDOW_SLOTS - 1);
  localparam logic [SlotW:0]    SlotCnt  = (SlotW + 1)'(WINDOW_SLOTS);
  localparam logic [LimW-1:0]   LimMaxV  = LimW'(LimMax);
  localparam logic [BlkLenW-1:0] PktLen  = BlkLenW'(PACKET_BYTES % (1 << BlkLenW));

  state_e                  state_q, state_d;
  logic [LenW-1:0]         xfer_len_q;
  logic [LimW-1:0]         win_limit_q;
  logic [WinW-1:0]         low_q, low_d, high_q, high_d, cur_q, cur_d;
  logic [SlotW-1:0]        low_slot_q, low_slot_d, high_slot_q, high_slot_d;
  logic [SlotW-1:0]        cur_slot_q, cur_slot_d;
  logic [WINDOW_SLOTS-1:0] acked_q, acked_d;
  logic [IdxW-1:0]         final_blk_q, final_blk_d;
  logic [BlkLenW-1:0]      final_len_q, final_len_d;
  logic                    active_q, active_d;
  logic [OpW-1:0]          op_q, op_d;
  logic [IdxW-1:0]         ack_q, ack_d;
  logic                    ign_q, ign_d;
  logic                    pend_valid_q, pend_valid_d;
  result_t                 pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_last_q, out_last_d;
  result_t                 out_q, out_d;

  logic                    acc, out_busy, cfg_wr;
  logic [LimW-1:0]         eff_limit;
  logic [WinW-1:0]         span, final_plus1, ack_ext, ack_diff;
  logic [SlotW:0]          ack_sum;
  logic [SlotW-1:0]        ack_slot;
  logic                    in_win, fill_go, slide_go, scan_go, done_cond;
  logic [BlkLenW-1:0]      len_high, len_cur;
  logic                    gen_valid, stall, take, push_mid, fin_go;
  result_t                 gen_res, fin_res;
  logic                    div_start, div_done;
  logic [IdxW-1:0]         div_quot;
  logic [BlkLenW-1:0]      div_rem;

  // configuration port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_TRANSFER_LENGTH: prdata = DataW'(xfer_len_q);
      REG_WINDOW_LIMIT:    prdata = DataW'(win_limit_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xfer_len_q  <= TransferLengthRst;
      win_limit_q <= WindowLimitRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TRANSFER_LENGTH: xfer_len_q  <= pwdata[LenW-1:0];
        REG_WINDOW_LIMIT:    win_limit_q <= pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  // block length divider
  assign div_start = acc && (req_i.operation == OP_START);

  srsw_div #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (xfer_len_q),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // window arithmetic
  assign acc         = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_busy    = out_valid_q && !rsp_o.ready;

  assign eff_limit   = (win_limit_q == '0) ? LimW'(1) :
                       (win_limit_q > LimMaxV) ? LimMaxV : win_limit_q;
  assign span        = high_q - low_q;
  assign final_plus1 = {1'b0, final_blk_q} + WinW'(1);
  assign fill_go     = (span < WinW'(eff_limit)) && (high_q != final_plus1);
  assign slide_go    = (low_q < high_q) && acked_q[low_slot_q];
  assign scan_go     = (cur_q < high_q);
  assign done_cond   = (low_q == high_q) && (low_q == final_plus1);
  assign len_high    = (high_q == {1'b0, final_blk_q}) ? final_len_q : PktLen;
  assign len_cur     = (cur_q == {1'b0, final_blk_q}) ? final_len_q : PktLen;

  assign ack_ext  = {1'b0, req_i.ack_index};
  assign in_win   = active_q && (ack_ext >= low_q) && (ack_ext < high_q);
  assign ack_diff = ack_ext - low_q;
  assign ack_sum  = {1'b0, low_slot_q} + {1'b0, ack_diff[SlotW-1:0]};
  assign ack_slot = (ack_sum >= SlotCnt) ? SlotW'(ack_sum - SlotCnt) : SlotW'(ack_sum);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (op_e'(req_i.operation))
            OP_START:   state_d = ST_DIV;
            OP_ACK:     state_d = in_win ? ST_SLIDE : ST_FINISH;
            OP_TIMEOUT: state_d = active_q ? ST_SCAN : ST_FINISH;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_DIV:    if (div_done) state_d = ST_FILL;
      ST_SLIDE:  if (!slide_go) state_d = ST_FILL;
      ST_FILL:   if (!fill_go) state_d = ST_FINISH;
      ST_SCAN:   if (!scan_go) state_d = ST_FINISH;
      ST_FINISH: if (!out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    gen_valid = 1'b0;
    gen_res   = '{kind: EV_NONE, idx: '0, len: '0};
    case (state_q)
      ST_FILL: begin
        if (fill_go) begin
          gen_valid = 1'b1;
          gen_res   = '{kind: EV_SEND, idx: high_q[IdxW-1:0], len: len_high};
        end
      end
      ST_SCAN: begin
        if (scan_go && !acked_q[cur_slot_q]) begin
          gen_valid = 1'b1;
          gen_res   = '{kind: EV_RESEND, idx: cur_q[IdxW-1:0], len: len_cur};
        end
      end
      default: ;
    endcase

    if (op_q == OP_ACK && ign_q) begin
      fin_res = '{kind: EV_IGNORED, idx: ack_q, len: '0};
    end else if (op_q == OP_ACK && done_cond) begin
      fin_res = '{kind: EV_DONE, idx: '0, len: '0};
    end else if (pend_valid_q) begin
      fin_res = pend_q;
    end else begin
      fin_res = '{kind: EV_NONE, idx: '0, len: '0};
    end
  end

  assign stall    = gen_valid && pend_valid_q && out_busy;
  assign take     = gen_valid && !stall;
  assign push_mid = take && pend_valid_q;
  assign fin_go   = (state_q == ST_FINISH) && !out_busy;

  // window state
  always_comb begin
    low_d       = low_q;
    high_d      = high_q;
    cur_d       = cur_q;
    low_slot_d  = low_slot_q;
    high_slot_d = high_slot_q;
    cur_slot_d  = cur_slot_q;
    acked_d     = acked_q;
    final_blk_d = final_blk_q;
    final_len_d = final_len_q;
    active_d    = active_q;
    op_d        = op_q;
    ack_d       = ack_q;
    ign_d       = ign_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          op_d  = req_i.operation;
          ack_d = req_i.ack_index;
          ign_d = !in_win;
          case (op_e'(req_i.operation))
            OP_START: begin
              low_d       = '0;
              high_d      = '0;
              low_slot_d  = '0;
              high_slot_d = '0;
              acked_d     = '0;
              active_d    = 1'b1;
            end
            OP_ACK: if (in_win) acked_d[ack_slot] = 1'b1;
            OP_TIMEOUT: begin
              cur_d      = low_q;
              cur_slot_d = low_slot_q;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          final_blk_d = div_quot;
          final_len_d = div_rem;
        end
      end
      ST_SLIDE: begin
        if (slide_go) begin
          acked_d[low_slot_q] = 1'b0;
          low_d               = low_q + WinW'(1);
          low_slot_d          = (low_slot_q == SlotLast) ? '0 : low_slot_q + SlotW'(1);
        end
      end
      ST_FILL: begin
        if (fill_go && !stall) begin
          acked_d[high_slot_q] = 1'b0;
          high_d               = high_q + WinW'(1);
          high_slot_d          = (high_slot_q == SlotLast) ? '0 : high_slot_q + SlotW'(1);
        end
      end
      ST_SCAN: begin
        if (scan_go && !stall) begin
          cur_d      = cur_q + WinW'(1);
          cur_slot_d = (cur_slot_q == SlotLast) ? '0 : cur_slot_q + SlotW'(1);
        end
      end
      ST_FINISH: begin
        if (fin_go && op_q == OP_ACK && !ign_q && done_cond) active_d = 1'b0;
      end
      default: ;
    endcase
  end

  // result staging: one pending result ahead of the output register
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    if (take) begin
      pend_valid_d = 1'b1;
      pend_d       = gen_res;
    end else if (fin_go) begin
      pend_valid_d = 1'b0;
    end
    if (push_mid) begin
      out_valid_d = 1'b1;
      out_d       = pend_q;
      out_last_d  = 1'b0;
    end else if (fin_go) begin
      out_valid_d = 1'b1;
      out_d       = fin_res;
      out_last_d  = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      low_q        <= '0;
      high_q       <= '0;
      low_slot_q   <= '0;
      high_slot_q  <= '0;
      acked_q      <= '0;
      final_blk_q  <= '0;
      final_len_q  <= '0;
      active_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      low_q        <= low_d;
      high_q       <= high_d;
      low_slot_q   <= low_slot_d;
      high_slot_q  <= high_slot_d;
      acked_q      <= acked_d;
      final_blk_q  <= final_blk_d;
      final_len_q  <= final_len_d;
      active_q     <= active_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    cur_slot_q <= cur_slot_d;
    op_q       <= op_d;
    ack_q      <= ack_d;
    ign_q      <= ign_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.event_kind   = out_q.kind;
  assign rsp_o.block_index  = out_q.idx;
  assign rsp_o.block_length = out_q.len;
  assign rsp_o.last         = out_last_q;

  a_span_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (high_q - low_q) <= WinW'(LimMax))
    else $error("window span beyond slot bound");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !pend_valid_q)
    else $error("pending result left behind at idle");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (out_valid_q && out_last_q))
    else $error("closing result not marked last");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its state");

endmodule

`default_nettype wire

FILE: test/selective_repeat_send_window_test.sv
`timescale 1ns / 100ps
// testbench of the selective-repeat send window, directed and random items against a model
module selective_repeat_send_window_test;
  import srsw_pkg::*;

  localparam logic [OpW-1:0]   OpUnused   = 2'd3;
  localparam logic [AddrW-1:0] AddrLength = AddrW'({REG_TRANSFER_LENGTH, 2'b00});
  localparam logic [AddrW-1:0] AddrLimit  = AddrW'({REG_WINDOW_LIMIT, 2'b00});
  localparam logic [IdxW-1:0]  IdxMax     = '1;
  localparam logic [LenW-1:0]  LengthMax  = '1;

  typedef struct {
    event_e             kind;
    logic [IdxW-1:0]    idx;
    logic [BlkLenW-1:0] len;
    logic               last;
  } block_event_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  srsw_req_if req_ch ();
  srsw_rsp_if rsp_ch ();

  selective_repeat_send_window dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bit          calm      = 1'b0;
  int unsigned long_hold = 0;
  int unsigned errors    = 0;

  block_event_t awaited_events[$];
  block_event_t item_events[$];

  // register shadows and window model
  int unsigned                cfg_length  = TransferLengthRst;
  int unsigned                cfg_limit   = WindowLimitRst;
  int unsigned                win_lo      = 0;
  int unsigned                win_hi      = 0;
  int unsigned                final_idx   = 0;
  int unsigned                final_bytes = 0;
  logic [WindowSlotsDef-1:0]  slot_done   = '0;
  bit                         sending     = 1'b0;

  always #5 clk_i = ~clk_i;

  function automatic void emit_event(event_e kind, int unsigned idx, int unsigned len);
    block_event_t e;
    if (item_events.size() >= ResultCap) return;
    e.kind = kind;
    e.idx  = idx[IdxW-1:0];
    e.len  = len[BlkLenW-1:0];
    e.last = 1'b0;
    item_events.push_back(e);
  endfunction

  function automatic int unsigned block_bytes(int unsigned idx);
    return (idx == final_idx) ? final_bytes : PacketBytesDef;
  endfunction

  function automatic void refill();
    int unsigned w;
    w = (cfg_limit == 0) ? 1 : cfg_limit;
    if (w > WindowSlotsDef) w = WindowSlotsDef;
    if (w > ResultCap) w = ResultCap;
    while (win_hi - win_lo < w && win_hi != final_idx + 1 && item_events.size() < ResultCap) begin
      slot_done[win_hi % WindowSlotsDef] = 1'b0;
      emit_event(EV_SEND, win_hi, block_bytes(win_hi));
      win_hi++;
    end
  endfunction

  function automatic void forecast_events(logic [OpW-1:0] op, logic [IdxW-1:0] ack);
    item_events.delete();
    case (op)
      OP_START: begin
        final_idx   = cfg_length / PacketBytesDef;
        final_bytes = cfg_length - final_idx * PacketBytesDef;
        win_lo      = 0;
        win_hi      = 0;
        slot_done   = '0;
        sending     = 1'b1;
        refill();
        if (item_events.size() == 0) emit_event(EV_NONE, 0, 0);
      end
      OP_ACK: begin
        if (!sending || ack < win_lo || ack >= win_hi) begin
          emit_event(EV_IGNORED, ack, 0);
        end else begin
          slot_done[ack % WindowSlotsDef] = 1'b1;
          while (win_lo < win_hi && slot_done[win_lo % WindowSlotsDef]) begin
            slot_done[win_lo % WindowSlotsDef] = 1'b0;
            win_lo++;
          end
          refill();
          if (win_lo == win_hi && win_lo == final_idx + 1) begin
            sending = 1'b0;
            emit_event(EV_DONE, 0, 0);
          end else if (item_events.size() == 0) begin
            emit_event(EV_NONE, 0, 0);
          end
        end
      end
      OP_TIMEOUT: begin
        if (sending) begin
          for (int unsigned i = win_lo; i < win_hi && item_events.size() < ResultCap; i++) begin
            if (!slot_done[i % WindowSlotsDef]) emit_event(EV_RESEND, i, block_bytes(i));
          end
        end
        if (item_events.size() == 0) emit_event(EV_NONE, 0, 0);
      end
      default: begin
        emit_event(EV_NONE, 0, 0);
      end
    endcase
    item_events[item_events.size() - 1].last = 1'b1;
    foreach (item_events[i]) awaited_events.push_back(item_events[i]);
  endfunction

  task automatic check_event();
    block_event_t e;
    if (awaited_events.size() == 0) begin
      errors++;
      $display("%0t: unexpected result kind %0d index %0d length %0d last %0d", $realtime,
               rsp_ch.event_kind, rsp_ch.block_index, rsp_ch.block_length, rsp_ch.last);
      return;
    end
    e = awaited_events.pop_front();
    if (rsp_ch.event_kind !== e.kind || rsp_ch.block_index !== e.idx ||
        rsp_ch.block_length !== e.len || rsp_ch.last !== e.last) begin
      errors++;
      $display("%0t: expected kind/index/length/last %0d %0d %0d %0d, got %0d %0d %0d %0d",
               $realtime, e.kind, e.idx, e.len, e.last, rsp_ch.event_kind,
               rsp_ch.block_index, rsp_ch.block_length, rsp_ch.last);
    end
  endtask

  // register write; back_to_back keeps the bus selected for a following write
  task automatic apb_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data, bit back_to_back);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == AddrLength) cfg_length = data[LenW-1:0];
    else cfg_limit = data[LimW-1:0];
    if (!back_to_back) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  task automatic configure(logic [LenW-1:0] len, logic [LimW-1:0] lim);
    apb_write(AddrLength, {1'($urandom), len}, 1'b1);
    apb_write(AddrLimit, {27'($urandom), lim}, 1'b0);
  endtask

  task automatic send_item(logic [OpW-1:0] op, logic [IdxW-1:0] ack);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.ack_index <= ack;
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
    forecast_events(op, ack);
  endtask

  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_idle_and_single_block();
    send_item(OP_ACK, '0);
    send_item(OP_ACK, IdxMax);
    send_item(OP_TIMEOUT, IdxMax);
    send_item(OpUnused, IdxMax);
    send_item(OP_START, '0);
    send_item(OP_TIMEOUT, '0);
    send_item(OP_ACK, IdxW'(1));
    send_item(OP_ACK, '0);
    send_item(OP_ACK, '0);
    wait_drain();
  endtask

  task automatic test_window_bounds();
    // limit zero acts as one, final block of zero bytes
    configure(LenW'(PacketBytesDef), '0);
    send_item(OP_START, IdxMax);
    send_item(OP_ACK, IdxW'(1));
    send_item(OP_ACK, '0);
    send_item(OP_ACK, IdxW'(1));
    wait_drain();
    // saturated limit, longest transfer
    configure(LengthMax, '1);
    send_item(OP_START, '0);
    send_item(OP_ACK, IdxW'(5));
    send_item(OP_TIMEOUT, '0);
    send_item(OP_ACK, '0);
    wait_drain();
    apb_write(AddrLimit, DataW'(17), 1'b0);
    send_item(OP_ACK, IdxW'(1));
    wait_drain();
    apb_write(AddrLimit, DataW'(WindowSlotsDef), 1'b0);
    send_item(OP_START, IdxMax);
    send_item(OP_ACK, IdxW'(WindowSlotsDef));
    send_item(OP_ACK, IdxMax);
    wait_drain();
  endtask

  task automatic test_output_stall();
    configure(LenW'(64 * PacketBytesDef), LimW'(WindowSlotsDef));
    long_hold = 150;
    send_item(OP_START, '0);
    send_item(OP_TIMEOUT, '0);
    send_item(OP_ACK, IdxW'(3));
    send_item(OP_TIMEOUT, '0);
    send_item(OpUnused, '0);
    wait_drain();
  endtask

  task automatic test_random_transfers(int unsigned n_items);
    int unsigned      issued;
    int unsigned      per_xfer;
    int unsigned      r;
    logic [LenW-1:0]  len;
    logic [LimW-1:0]  lim;
    int unsigned      open_slots[$];
    issued = 0;
    while (issued < n_items) begin
      wait_drain();
      r = $urandom_range(0, 19);
      if (r < 13) len = $urandom_range(1, 8 * PacketBytesDef);
      else if (r < 16) len = $urandom_range(1, PacketBytesDef);
      else if (r < 19) len = $urandom_range(1, 8) * PacketBytesDef;
      else len = $urandom_range(1, 32'h7FFF_FFFF);
      lim = ($urandom_range(0, 9) < 6) ? $urandom_range(1, WindowSlotsDef) : $urandom_range(0, 31);
      configure(len, lim);
      send_item(OP_START, IdxW'($urandom));
      issued++;
      per_xfer = 0;
      while (sending && issued < n_items && per_xfer < 40) begin
        r = $urandom_range(0, 99);
        if (r >= 96) begin
          wait_drain();
          apb_write(AddrLimit, {27'($urandom), 5'($urandom)}, 1'b0);
        end else begin
          if (r < 70) begin
            open_slots.delete();
            for (int unsigned i = win_lo; i < win_hi; i++) begin
              if (!slot_done[i % WindowSlotsDef]) open_slots.push_back(i);
            end
            if (open_slots.size() == 0) send_item(OP_TIMEOUT, IdxW'($urandom));
            else send_item(OP_ACK, IdxW'(open_slots[$urandom_range(0, open_slots.size() - 1)]));
          end else if (r < 76) begin
            // just outside the window on either side
            if (win_lo == 0 || $urandom_range(0, 1) == 0) send_item(OP_ACK, IdxW'(win_hi));
            else send_item(OP_ACK, IdxW'(win_lo - 1));
          end else if (r < 84) begin
            send_item(OP_TIMEOUT, IdxW'($urandom));
          end else if (r < 90) begin
            send_item(OP_ACK, IdxW'($urandom));
          end else if (r < 93) begin
            send_item(OpUnused, IdxW'($urandom));
          end else begin
            send_item(OP_START, IdxW'($urandom));
          end
          issued++;
          per_xfer++;
        end
      end
    end
    wait_drain();
  endtask

  // result side: checks every transfer and throttles ready
  initial begin : result_sink
    int unsigned pause;
    pause = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_ch.valid && rsp_ch.ready) check_event();
      if (long_hold != 0) begin
        long_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (pause != 0) begin
        pause--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pause = $urandom_range(0, 6);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_START;
    req_ch.ack_index <= '0;
    rsp_ch.ready     <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_and_single_block();
    test_window_bounds();
    test_output_stall();
    test_random_transfers(150);
    calm = 1'b1;
    test_random_transfers(40);
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("selective_repeat_send_window_test OK");
    end else begin
      $display("selective_repeat_send_window_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("selective_repeat_send_window_test NOT OK");
    $finish;
  end

endmodule

FILE: files.f
hdl/srsw_pkg.sv
hdl/srsw_if.sv
hdl/srsw_div.sv
hdl/selective_repeat_send_window.sv
test/selective_repeat_send_window_test.sv
